[sv/ccw_pkg.sv]
// shared types and constants of the coin change way counter
// no dependencies; used by every other file of the block but ccw_ram

package ccw_pkg;

  localparam int unsigned AMT_W      = 15;
  localparam int unsigned WAY_W      = 63;
  localparam int unsigned COIN_W     = 14;
  localparam int unsigned COIN_IDX_W = 4;

  // source of the word written into the ways table
  typedef enum logic [1:0] {
    WR_ZERO,
    WR_ONE,
    WR_SUM
  } wr_src_e;

  // sequencer to datapath control
  typedef struct packed {
    logic    we;
    wr_src_e src;
    logic    out_load;
    logic    out_zero;
  } ccw_ctl_t;

  // coin and note values in cents, largest first; unused slots are zero
  function automatic logic [COIN_W-1:0] coin_value(input logic [COIN_IDX_W-1:0] idx);
    logic [COIN_W-1:0] val;
    unique case (idx)
      4'd0:    val = 14'd10000;
      4'd1:    val = 14'd5000;
      4'd2:    val = 14'd2000;
      4'd3:    val = 14'd1000;
      4'd4:    val = 14'd500;
      4'd5:    val = 14'd200;
      4'd6:    val = 14'd100;
      4'd7:    val = 14'd50;
      4'd8:    val = 14'd20;
      4'd9:    val = 14'd10;
      4'd10:   val = 14'd5;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[sv/ccw_in_if.sv]
// query channel of the coin change way counter: valid, ready, amount
// depends on ccw_pkg

interface ccw_in_if;
  logic                         valid;
  logic                         ready;
  logic [ccw_pkg::AMT_W-1:0]    amount_cents;

  modport source (output valid, output amount_cents, input ready);
  modport sink   (input valid, input amount_cents, output ready);
endinterface

[sv/ccw_out_if.sv]
// result channel of the coin change way counter: valid, ready, way count
// depends on ccw_pkg

interface ccw_out_if;
  logic                         valid;
  logic                         ready;
  logic [ccw_pkg::WAY_W-1:0]    way_count;

  modport source (output valid, output way_count, input ready);
  modport sink   (input valid, input way_count, output ready);
endinterface

[sv/ccw_ram.sv]
// generic synchronous ram: one write port, two read ports, registered reads
// no dependencies

module ccw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[sv/ccw_seq.sv]
// sequencer: table clear sweep, per-coin fill passes and query lookups
// depends on ccw_pkg; drives the addresses of ccw_ram and the datapath control

module ccw_seq #(
  parameter int unsigned MAX_AMOUNT = 32767,
  parameter int unsigned NUM_COINS  = 11
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [ccw_pkg::AMT_W-1:0]         amount_i,
  input  logic                              out_busy_i,
  output logic                              in_ready_o,
  output logic [$clog2(MAX_AMOUNT+1)-1:0]   raddr_a_o,
  output logic [$clog2(MAX_AMOUNT+1)-1:0]   raddr_b_o,
  output logic [$clog2(MAX_AMOUNT+1)-1:0]   waddr_o,
  output ccw_pkg::ccw_ctl_t                 ctl_o
);

  localparam int unsigned AW  = $clog2(MAX_AMOUNT + 1);
  localparam int unsigned CIW = $clog2(NUM_COINS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_COIN,
    S_FILL,
    S_LOOK,
    S_RESULT
  } state_e;

  state_e                      state_q;
  logic                        built_q;
  logic [ccw_pkg::AMT_W-1:0]   amount_q;
  logic [AW-1:0]               addr_q;
  logic [CIW-1:0]              coin_q;
  logic [ccw_pkg::COIN_W-1:0]  coin_val_q;
  logic                        pend_q;
  logic [AW-1:0]               pend_addr_q;

  logic [ccw_pkg::COIN_W-1:0]  coin_val;
  logic                        coin_skip;
  logic                        addr_last;
  logic                        amt_in_range;

  assign coin_val     = ccw_pkg::coin_value(ccw_pkg::COIN_IDX_W'(coin_q));
  assign coin_skip    = (coin_val == '0) || (17'(coin_val) > 17'(MAX_AMOUNT));
  assign addr_last    = (addr_q == AW'(MAX_AMOUNT));
  assign amt_in_range = (17'(amount_q) <= 17'(MAX_AMOUNT));

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    unique case (state_q)
      S_IDLE:  raddr_a_o = AW'(amount_i);
      S_FILL:  raddr_a_o = addr_q;
      default: raddr_a_o = AW'(amount_q);
    endcase
    raddr_b_o = addr_q - AW'(coin_val_q);
    waddr_o   = (state_q == S_CLEAR) ? addr_q : pend_addr_q;

    ctl_o.we       = (state_q == S_CLEAR) || pend_q;
    ctl_o.src      = ccw_pkg::WR_SUM;
    if (state_q == S_CLEAR) begin
      ctl_o.src = (addr_q == '0) ? ccw_pkg::WR_ONE : ccw_pkg::WR_ZERO;
    end
    ctl_o.out_load = (state_q == S_RESULT) && !out_busy_i;
    ctl_o.out_zero = !amt_in_range;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      built_q     <= 1'b0;
      amount_q    <= '0;
      addr_q      <= '0;
      coin_q      <= '0;
      coin_val_q  <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
    end else begin
      pend_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            amount_q <= amount_i;
            addr_q   <= '0;
            state_q  <= built_q ? S_RESULT : S_CLEAR;
          end
        end
        S_CLEAR: begin
          addr_q <= addr_q + 1'b1;
          if (addr_last) begin
            coin_q  <= '0;
            state_q <= S_COIN;
          end
        end
        S_COIN: begin
          // passing through this state between passes lets the last write of a pass land
          if (coin_q == CIW'(NUM_COINS)) begin
            built_q <= 1'b1;
            state_q <= S_LOOK;
          end else if (coin_skip) begin
            coin_q <= coin_q + 1'b1;
          end else begin
            coin_val_q <= coin_val;
            addr_q     <= AW'(coin_val);
            state_q    <= S_FILL;
          end
        end
        S_FILL: begin
          // ways[a] += ways[a - coin]; sum is written in the cycle after the reads
          pend_q      <= 1'b1;
          pend_addr_q <= addr_q;
          addr_q      <= addr_q + 1'b1;
          if (addr_last) begin
            coin_q  <= coin_q + 1'b1;
            state_q <= S_COIN;
          end
        end
        S_LOOK: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_busy_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/coin_change_way_counter_top.sv]
// top level of the coin change way counter: ways table ram, sequencer,
// saturating update adder and result register; depends on ccw_pkg,
// ccw_in_if, ccw_out_if, ccw_ram and ccw_seq
//
// usage: each item on in_i carries amount_cents; one item on out_o carries
// way_count, the number of unordered ways to make that amount from the notes
// and coins 10000..5 cents. amounts above MAX_AMOUNT give zero.
// the first item after reset builds the ways table in ram: a clear sweep over
// every entry, then one fill pass per usable coin from its value up to
// MAX_AMOUNT, with a visit to the coin state between passes. the single
// write port of the ram sets the fill rate of one table entry per cycle.
// every later item is one ram read: the data is registered in the ram, then
// in the result register on out_o, and in_ready returns in the same cycle
// that the result appears, so an item is accepted only once the last one
// has been loaded into the result register.
// reset clears the control state and marks the table as not built; its ram
// contents are never cleared, only overwritten by the next build.
// out_o holds its item until taken; while it waits one more item can be
// accepted, and that item then waits in the sequencer until out_o frees up.

module coin_change_way_counter_top #(
  parameter int unsigned MAX_AMOUNT = 32767,
  parameter int unsigned NUM_COINS  = 11
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ccw_in_if.sink       in_i,
  ccw_out_if.source    out_o
);

  localparam int unsigned DEPTH = MAX_AMOUNT + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [AW-1:0]               raddr_a;
  logic [AW-1:0]               raddr_b;
  logic [AW-1:0]               waddr;
  logic [ccw_pkg::WAY_W-1:0]   rdata_a;
  logic [ccw_pkg::WAY_W-1:0]   rdata_b;
  logic [ccw_pkg::WAY_W-1:0]   wdata;
  logic [ccw_pkg::WAY_W:0]     sum;
  logic [ccw_pkg::WAY_W-1:0]   sum_sat;
  ccw_pkg::ccw_ctl_t           ctl;
  logic                        out_busy;

  logic                        out_valid_q;
  logic                        out_valid_d;
  logic [ccw_pkg::WAY_W-1:0]   out_count_q;
  logic [ccw_pkg::WAY_W-1:0]   out_count_d;

  ccw_seq #(
    .MAX_AMOUNT (MAX_AMOUNT),
    .NUM_COINS  (NUM_COINS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .amount_i   (in_i.amount_cents),
    .out_busy_i (out_busy),
    .in_ready_o (in_i.ready),
    .raddr_a_o  (raddr_a),
    .raddr_b_o  (raddr_b),
    .waddr_o    (waddr),
    .ctl_o      (ctl)
  );

  ccw_ram #(
    .WIDTH (ccw_pkg::WAY_W),
    .DEPTH (DEPTH)
  ) u_ways_ram (
    .clk_i     (clk_i),
    .we_i      (ctl.we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // counts saturate at the top of the 63-bit range
  assign sum     = {1'b0, rdata_a} + {1'b0, rdata_b};
  assign sum_sat = sum[ccw_pkg::WAY_W] ? '1 : sum[ccw_pkg::WAY_W-1:0];

  always_comb begin
    unique case (ctl.src)
      ccw_pkg::WR_ZERO: wdata = '0;
      ccw_pkg::WR_ONE:  wdata = ccw_pkg::WAY_W'(1);
      ccw_pkg::WR_SUM:  wdata = sum_sat;
      default:          wdata = '0;
    endcase
  end

  assign out_busy = out_valid_q && !out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    if (ctl.out_load) begin
      out_valid_d = 1'b1;
      out_count_d = ctl.out_zero ? '0 : rdata_a;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.way_count = out_count_q;

endmodule

[sv/ccw_checker.sv]
// port-level checks of the coin change way counter, bound to the top level
// depends on ccw_pkg and coin_change_way_counter_top

module ccw_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [ccw_pkg::WAY_W-1:0]    way_count_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] open_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(way_count_i))
    else $error("result item changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> open_q != 2'd0)
    else $error("result item without a query");

  a_two_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> open_q == 2'd0 || open_q == 2'd1)
    else $error("query taken with two items already open");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("query taken on consecutive cycles");

endmodule

bind coin_change_way_counter_top ccw_checker u_ccw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .way_count_i (out_o.way_count)
);

[tb/testbench.sv]
// self-checking bench for coin_change_way_counter_top: queues amount queries,
// predicts each way count from its own bottom-up table, checks out_o in order
// depends on ccw_pkg, ccw_in_if, ccw_out_if and the rtl of the block

module testbench;

  localparam int unsigned MAX_AMOUNT  = 32767;
  localparam int unsigned NUM_COINS   = 11;
  localparam int unsigned RAND_ITEMS  = 2000;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned COIN_CENTS [NUM_COINS] =
    '{10000, 5000, 2000, 1000, 500, 200, 100, 50, 20, 10, 5};

  // pending queues keep the newest entry at the front and the oldest at the back
  typedef struct {
    logic [ccw_pkg::AMT_W-1:0] amount;
    bit                        drain_first;
  } query_t;

  typedef struct {
    logic [ccw_pkg::AMT_W-1:0] amount;
    logic [ccw_pkg::WAY_W-1:0] ways;
  } way_check_t;

  logic clk_i;
  logic rst_ni;

  ccw_in_if  in_if ();
  ccw_out_if out_if ();

  coin_change_way_counter_top #(
    .MAX_AMOUNT(MAX_AMOUNT),
    .NUM_COINS (NUM_COINS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [ccw_pkg::WAY_W-1:0] way_table [0:MAX_AMOUNT];
  query_t                    query_q [$];
  way_check_t                way_expect_q [$];
  int                        queries_sent;
  int                        results_seen;
  int                        error_count;
  int                        burst_left;
  int                        gap_left;
  logic [15:0]               stall_pat;
  int                        pat_left;
  way_check_t                oldest;

  // counts for every amount, one coin folded in at a time, saturating
  function automatic void build_way_table();
    logic [ccw_pkg::WAY_W:0] sum;
    for (int a = 0; a <= MAX_AMOUNT; a++) way_table[a] = '0;
    way_table[0] = ccw_pkg::WAY_W'(1);
    for (int k = 0; k < NUM_COINS; k++) begin
      if (COIN_CENTS[k] == 0 || COIN_CENTS[k] > MAX_AMOUNT) continue;
      for (int a = COIN_CENTS[k]; a <= MAX_AMOUNT; a++) begin
        sum = {1'b0, way_table[a]} + {1'b0, way_table[a - COIN_CENTS[k]]};
        way_table[a] = sum[ccw_pkg::WAY_W] ? {ccw_pkg::WAY_W{1'b1}}
                                           : sum[ccw_pkg::WAY_W-1:0];
      end
    end
  endfunction

  function automatic logic [ccw_pkg::WAY_W-1:0] ways_for(
    input logic [ccw_pkg::AMT_W-1:0] amount);
    if (amount > MAX_AMOUNT) return '0;
    return way_table[amount];
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout, %0d results still expected", $time, way_expect_q.size());
    $display("FAIL");
    $finish;
  end

  // sender: bursts of items with random gaps, optional drain before an item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.amount_cents <= '0;
      burst_left         <= 0;
      gap_left           <= 0;
      queries_sent       <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        way_expect_q.push_front('{amount: in_if.amount_cents,
                                  ways: ways_for(in_if.amount_cents)});
        queries_sent <= queries_sent + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (query_q.size() == 0 ||
                     (query_q[$].drain_first &&
                      (in_if.valid || queries_sent != results_seen))) begin
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid        <= 1'b1;
          in_if.amount_cents <= query_q[$].amount;
          void'(query_q.pop_back());
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stalls follow a rotating pattern, swapped now and then
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_pat    <= '1;
      pat_left     <= 0;
      results_seen <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        if (way_expect_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got way_count %0d",
                   $time, out_if.way_count);
          error_count++;
        end else begin
          oldest = way_expect_q.pop_back();
          if (out_if.way_count !== oldest.ways) begin
            $display("%0t: amount %0d way_count expected %0d, got %0d",
                     $time, oldest.amount, oldest.ways, out_if.way_count);
            error_count++;
          end
        end
      end
      out_if.ready <= stall_pat[0];
      if (pat_left == 0) begin
        stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom());
        pat_left  <= $urandom_range(16, 200);
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
        pat_left  <= pat_left - 1;
      end
    end
  end

  initial begin
    logic [ccw_pkg::AMT_W-1:0] amt;
    int unsigned               directed [$];

    error_count = 0;
    rst_ni      = 1'b0;

    build_way_table();

    // edges, every coin value, non-multiples of five, bit patterns
    directed = '{0, 5, 1, 2, 3, 4, 10, 20, 50, 100, 200, 500, 1000, 2000, 5000,
                 10000, 30000, 32765, 32766, 32767, 16384, 21845, 10922, 7};
    foreach (directed[i])
      query_q.push_front('{amount: ccw_pkg::AMT_W'(directed[i]), drain_first: 1'b0});

    for (int n = 0; n < RAND_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0, 1:    amt = ccw_pkg::AMT_W'($urandom_range(0, MAX_AMOUNT));
        2, 3:    amt = ccw_pkg::AMT_W'(5 * $urandom_range(0, 40));
        4:       amt = ccw_pkg::AMT_W'(MAX_AMOUNT - $urandom_range(0, 30));
        default: amt = ccw_pkg::AMT_W'(5 * $urandom_range(0, MAX_AMOUNT / 5));
      endcase
      // hold off until the block has delivered everything now and then
      query_q.push_front('{amount: amt, drain_first: (n % 500 == 0)});
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (query_q.size() != 0 || in_if.valid || queries_sent != results_seen)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (way_expect_q.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, way_expect_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
